FILE: rtl/ppeu_pkg.sv
// ppeu_pkg: shared types, constants and helper functions for the pixel post effect unit
// used by ppeu_div, ppeu_dp, ppeu_ctrl and pixel_post_effect_unit; no dependencies
`default_nettype none

package ppeu_pkg;

  // frame and delay line limits
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MaxOffset  = 31;
  localparam int unsigned DelayDepth = MaxOffset;
  localparam int unsigned PtrW       = $clog2(DelayDepth);
  localparam int unsigned FillW      = $clog2(DelayDepth + 1);
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned SizeW      = 13;

  // field widths
  localparam int unsigned PixW       = 32;
  localparam int unsigned RandW      = 31;
  localparam int unsigned ParamOneW  = 16;
  localparam int unsigned ParamTwoW  = 9;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 96;

  // shared divider
  localparam int unsigned DivW       = RandW;
  localparam int unsigned DivisorW   = ParamOneW;
  localparam int unsigned DivCntW    = $clog2(DivW + 1);
  localparam int unsigned GateIters  = RandW;
  localparam int unsigned RowIters   = RowW;
  localparam int unsigned ChanIters  = 8;

  typedef enum logic [1:0] {
    MODE_NOISE = 2'd0,
    MODE_GHOST = 2'd1,
    MODE_SCAN  = 2'd2,
    MODE_PASS  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EFFECT_MODE  = 3'd0,
    CFG_PARAM_ONE    = 3'd1,
    CFG_PARAM_TWO    = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_GATE = 2'd0,
    DIV_ROW  = 2'd1,
    DIV_CHAN = 2'd2
  } div_sel_e;

  typedef enum logic {
    EMIT_HEAD = 1'b0,
    EMIT_RES  = 1'b1
  } emit_sel_e;

  typedef enum logic {
    BASE_PIX  = 1'b0,
    BASE_HEAD = 1'b1
  } base_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_DRAIN    = 4'd1,
    ST_DISPATCH = 4'd2,
    ST_DIV_GATE = 4'd3,
    ST_DIV_ROW  = 4'd4,
    ST_CH_START = 4'd5,
    ST_CH_WAIT  = 4'd6,
    ST_EMIT_RES = 4'd7,
    ST_PUSH     = 4'd8,
    ST_FLUSH    = 4'd9,
    ST_FINISH   = 4'd10
  } state_e;

  typedef struct packed {
    logic      capture;
    logic      div_start;
    div_sel_e  div_sel;
    logic [1:0] chan;
    logic      res_init;
    base_sel_e base_sel;
    logic      res_scan;
    logic      chan_update;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_last;
    logic      pop;
    logic      push;
    logic      count_update;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  drain_need;
    logic  fill_eq_off;
    logic  off_zero;
    logic  fill_zero;
    logic  fill_one;
    logic  row_end;
    logic  div_busy;
    logic  rem_zero;
    logic  out_free;
  } status_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // subtract with floor at zero
  function automatic logic [7:0] floor_sub8(input logic [7:0] c,
                                            input logic [ParamTwoW-1:0] amt);
    logic [ParamTwoW-1:0] cw;
    logic [ParamTwoW-1:0] dif;
    cw  = {1'b0, c};
    dif = cw - amt;
    return (cw >= amt) ? dif[7:0] : 8'd0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pixel_post_effect_unit.sv
// pixel_post_effect_unit: one pixel at a time through a shared one-bit-per-cycle divider
// (31 steps for the gate word, 12 for the row, 8 per channel); pass-through and ghost fills
// skip the divider, scanlines divide the row, a noise miss the gate word, a noise hit the
// gate word and each channel, ghost with zero offset and a ghost mix each channel; drained
// words, a row-end flush and output stalls lengthen an item
// reset loads the config defaults and clears counters and fill; delay line stays undefined
`default_nettype none

module pixel_post_effect_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ppeu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ppeu_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_in [31:0], gate_random [62:32], noise_random [93:63], zero pad [95:94]
  input  wire logic [ppeu_pkg::InDataW-1:0]   s_axis_tdata,
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // pixel_out [31:0]
  output logic [ppeu_pkg::PixW-1:0]           m_axis_tdata,
  output logic                                m_axis_tlast
);
  import ppeu_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  ppeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppeu_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_in_i     (s_axis_tdata[PixW-1:0]),
    .gate_random_i  (s_axis_tdata[PixW+RandW-1:PixW]),
    .noise_random_i (s_axis_tdata[PixW+2*RandW-1:PixW+RandW]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_out_o    (m_axis_tdata),
    .run_last_o     (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/ppeu_div.sv
// ppeu_div: radix-2 restoring divider, one quotient bit per cycle
// dividend comes left aligned with an iteration count; depends on ppeu_pkg
`default_nettype none

module ppeu_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [ppeu_pkg::DivW-1:0]      dividend_i,
  input  wire logic [ppeu_pkg::DivCntW-1:0]   iters_i,
  input  wire logic [ppeu_pkg::DivisorW-1:0]  divisor_i,
  output logic                                busy_o,
  output logic [ppeu_pkg::DivW-1:0]           quot_o,
  output logic [ppeu_pkg::DivisorW-1:0]       rem_o
);
  import ppeu_pkg::*;

  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]     sh_q, sh_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dv_q, dv_d;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                qbit;

  assign trial = {rem_q, sh_q[DivW-1]};
  assign diff  = trial - {1'b0, dv_q};
  assign qbit  = (trial >= {1'b0, dv_q});

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    rem_d = rem_q;
    dv_d  = dv_q;
    if (start_i) begin
      cnt_d = iters_i;
      sh_d  = dividend_i;
      rem_d = '0;
      dv_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DivCntW'(1);
      sh_d  = {sh_q[DivW-2:0], qbit};
      rem_d = qbit ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/ppeu_dp.sv
// ppeu_dp: datapath with config registers, counters, ghost delay line,
// shared divider, working result and output register; depends on ppeu_pkg, ppeu_div
`default_nettype none

module ppeu_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ppeu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [ppeu_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [ppeu_pkg::PixW-1:0]       pixel_in_i,
  input  wire logic [ppeu_pkg::RandW-1:0]      gate_random_i,
  input  wire logic [ppeu_pkg::RandW-1:0]      noise_random_i,
  input  wire ppeu_pkg::cmd_t                  cmd_i,
  output ppeu_pkg::status_t                    status_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [ppeu_pkg::PixW-1:0]            pixel_out_o,
  output logic                                 run_last_o
);
  import ppeu_pkg::*;

  // configuration
  mode_e                 mode_q;
  logic [ParamOneW-1:0]  p1_q;
  logic [ParamTwoW-1:0]  p2_q;
  logic [SizeW-1:0]      fw_q;
  logic [SizeW-1:0]      fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NOISE;
      p1_q   <= ParamOneW'(1);
      p2_q   <= ParamTwoW'(1);
      fw_q   <= SizeW'(640);
      fh_q   <= SizeW'(480);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EFFECT_MODE:  mode_q <= mode_e'(cfg_data_i[1:0]);
        CFG_PARAM_ONE:    p1_q   <= cfg_data_i;
        CFG_PARAM_TWO:    p2_q   <= cfg_data_i[ParamTwoW-1:0];
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i[SizeW-1:0];
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [ParamOneW-1:0] div_one;
  logic [ParamTwoW-1:0] div_two;
  logic [SizeW-1:0]     width_eff;
  logic [SizeW-1:0]     height_eff;
  logic [FillW-1:0]     off;
  logic                 ghost;

  assign ghost   = (mode_q == MODE_GHOST);
  assign div_one = (p1_q == '0) ? ParamOneW'(1) : p1_q;
  assign div_two = (p2_q == '0) ? ParamTwoW'(1) : p2_q;

  always_comb begin
    if (fw_q == '0)                     width_eff = SizeW'(1);
    else if (fw_q > SizeW'(MaxWidth))   width_eff = SizeW'(MaxWidth);
    else                                width_eff = fw_q;
    if (fh_q == '0)                     height_eff = SizeW'(1);
    else if (fh_q > SizeW'(MaxHeight))  height_eff = SizeW'(MaxHeight);
    else                                height_eff = fh_q;
    if (!ghost)                         off = '0;
    else if (p1_q > ParamOneW'(MaxOffset)) off = FillW'(MaxOffset);
    else                                off = p1_q[FillW-1:0];
  end

  // captured item
  logic [PixW-1:0]  pix_q;
  logic [RandW-1:0] gate_q;
  logic [RandW-1:0] noise_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q   <= pixel_in_i;
      gate_q  <= gate_random_i;
      noise_q <= noise_random_i;
    end
  end

  // position counters
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            row_end;
  logic            frame_end;

  assign row_end   = ((SizeW'(col_q) + SizeW'(1)) >= width_eff);
  assign frame_end = ((SizeW'(row_q) + SizeW'(1)) >= height_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.count_update) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // ghost delay line as a circular fifo
  logic [PixW-1:0]  line_q [DelayDepth];
  logic [PtrW-1:0]  head_q;
  logic [FillW-1:0] fill_q;
  logic [PtrW:0]    wr_sum;
  logic [PtrW-1:0]  wr_ptr;
  logic [PixW-1:0]  head_pix;

  assign wr_sum   = {1'b0, head_q} + (PtrW+1)'(fill_q);
  assign wr_ptr   = (wr_sum >= (PtrW+1)'(DelayDepth)) ?
                    PtrW'(wr_sum - (PtrW+1)'(DelayDepth)) : wr_sum[PtrW-1:0];
  assign head_pix = line_q[head_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      line_q[wr_ptr] <= pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.pop) begin
      head_q <= (head_q == PtrW'(DelayDepth - 1)) ? '0 : head_q + PtrW'(1);
      fill_q <= fill_q - FillW'(1);
    end else if (cmd_i.push) begin
      fill_q <= fill_q + FillW'(1);
    end
  end

  // shared divider
  logic [DivW-1:0]     div_dividend;
  logic [DivCntW-1:0]  div_iters;
  logic [DivisorW-1:0] div_divisor;
  logic                div_busy;
  logic [DivW-1:0]     div_quot;
  logic [DivisorW-1:0] div_rem;
  logic [PixW-1:0]     operand;
  logic [7:0]          op_byte;

  assign operand = ghost ? pix_q : {1'b0, noise_q};

  always_comb begin
    case (cmd_i.chan)
      2'd0:    op_byte = operand[7:0];
      2'd1:    op_byte = operand[15:8];
      default: op_byte = operand[23:16];
    endcase
    case (cmd_i.div_sel)
      DIV_GATE: begin
        div_dividend = gate_q;
        div_iters    = DivCntW'(GateIters);
        div_divisor  = div_one;
      end
      DIV_ROW: begin
        div_dividend = {row_q, {(DivW-RowW){1'b0}}};
        div_iters    = DivCntW'(RowIters);
        div_divisor  = div_one;
      end
      default: begin
        div_dividend = {op_byte, {(DivW-8){1'b0}}};
        div_iters    = DivCntW'(ChanIters);
        div_divisor  = DivisorW'(div_two);
      end
    endcase
  end

  ppeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .iters_i    (div_iters),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // working result
  logic [PixW-1:0] res_q;
  logic [7:0]      add_val;

  // ghost adds the quotient, noise adds the remainder
  assign add_val = ghost ? div_quot[7:0] : div_rem[7:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_init) begin
      res_q <= (cmd_i.base_sel == BASE_HEAD) ? head_pix : pix_q;
    end else if (cmd_i.res_scan) begin
      res_q <= {pix_q[31:24], floor_sub8(pix_q[23:16], p2_q),
                floor_sub8(pix_q[15:8], p2_q), floor_sub8(pix_q[7:0], p2_q)};
    end else if (cmd_i.chan_update) begin
      case (cmd_i.chan)
        2'd0:    res_q[7:0]   <= sat_add8(res_q[7:0], add_val);
        2'd1:    res_q[15:8]  <= sat_add8(res_q[15:8], add_val);
        default: res_q[23:16] <= sat_add8(res_q[23:16], add_val);
      endcase
    end
  end

  // output register
  logic            out_valid_q;
  logic [PixW-1:0] out_pix_q;
  logic            out_last_q;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pix_q  <= (cmd_i.emit_sel == EMIT_HEAD) ? head_pix : res_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign run_last_o  = out_last_q;

  always_comb begin
    status_o.mode        = mode_q;
    status_o.drain_need  = (fill_q > off);
    status_o.fill_eq_off = (fill_q == off);
    status_o.off_zero    = (off == '0);
    status_o.fill_zero   = (fill_q == '0);
    status_o.fill_one    = (fill_q == FillW'(1));
    status_o.row_end     = row_end;
    status_o.div_busy    = div_busy;
    status_o.rem_zero    = (div_rem == '0);
    status_o.out_free    = out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/ppeu_ctrl.sv
// ppeu_ctrl: sequencer that steps one pixel through drain, effect, push and flush
// drives the datapath by cmd_t and reads status_t; depends on ppeu_pkg
`default_nettype none

module ppeu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ppeu_pkg::status_t  status_i,
  output ppeu_pkg::cmd_t          cmd_o
);
  import ppeu_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] chan_q, chan_d;
  logic       ghost_run;

  // ghosting with a nonzero offset goes through the delay line
  assign ghost_run = (status_i.mode == MODE_GHOST) && !status_i.off_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.drain_need) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        chan_d = '0;
        case (status_i.mode)
          MODE_NOISE: state_d = ST_DIV_GATE;
          MODE_SCAN:  state_d = ST_DIV_ROW;
          MODE_GHOST: begin
            if (status_i.off_zero || status_i.fill_eq_off) state_d = ST_CH_START;
            else                                          state_d = ST_PUSH;
          end
          default:    state_d = ST_EMIT_RES;
        endcase
      end
      ST_DIV_GATE: begin
        if (!status_i.div_busy) begin
          state_d = status_i.rem_zero ? ST_CH_START : ST_EMIT_RES;
        end
      end
      ST_DIV_ROW: begin
        if (!status_i.div_busy) state_d = ST_EMIT_RES;
      end
      ST_CH_START: begin
        state_d = ST_CH_WAIT;
      end
      ST_CH_WAIT: begin
        if (!status_i.div_busy) begin
          if (chan_q == 2'd2) begin
            state_d = ST_EMIT_RES;
          end else begin
            chan_d  = chan_q + 2'd1;
            state_d = ST_CH_START;
          end
        end
      end
      ST_EMIT_RES: begin
        if (status_i.out_free) state_d = ghost_run ? ST_PUSH : ST_FINISH;
      end
      ST_PUSH: begin
        state_d = status_i.row_end ? ST_FLUSH : ST_FINISH;
      end
      ST_FLUSH: begin
        if (status_i.fill_zero) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.div_sel  = DIV_CHAN;
    cmd_o.base_sel = BASE_PIX;
    cmd_o.emit_sel = EMIT_HEAD;
    cmd_o.chan     = chan_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DRAIN: begin
        // pending pixels beyond the offset leave unchanged
        if (status_i.drain_need && status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.pop  = 1'b1;
        end
      end
      ST_DISPATCH: begin
        case (status_i.mode)
          MODE_NOISE: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_GATE;
          end
          MODE_SCAN: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_ROW;
          end
          MODE_GHOST: begin
            cmd_o.res_init = 1'b1;
            cmd_o.base_sel = status_i.off_zero ? BASE_PIX : BASE_HEAD;
          end
          default: begin
            cmd_o.res_init = 1'b1;
          end
        endcase
      end
      ST_DIV_GATE: begin
        cmd_o.div_sel  = DIV_GATE;
        cmd_o.res_init = !status_i.div_busy;
      end
      ST_DIV_ROW: begin
        cmd_o.div_sel = DIV_ROW;
        if (!status_i.div_busy) begin
          cmd_o.res_init = !status_i.rem_zero;
          cmd_o.res_scan = status_i.rem_zero;
        end
      end
      ST_CH_START: begin
        cmd_o.div_start = 1'b1;
      end
      ST_CH_WAIT: begin
        cmd_o.chan_update = !status_i.div_busy;
      end
      ST_EMIT_RES: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = EMIT_RES;
          cmd_o.emit_last = !(ghost_run && status_i.row_end);
          cmd_o.pop       = ghost_run;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
      end
      ST_FLUSH: begin
        if (!status_i.fill_zero && status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.pop       = 1'b1;
          cmd_o.emit_last = status_i.fill_one;
        end
      end
      ST_FINISH: begin
        cmd_o.count_update = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: verif/pixel_post_effect_unit_tb.sv
// pixel_post_effect_unit_tb: self-checking bench for the pixel post effect unit
// drives config writes and pixel words with random idling, predicts every output word
// in a scoreboard class and compares in order; depends on ppeu_pkg and the rtl top only

module pixel_post_effect_unit_tb;
  import ppeu_pkg::*;

  localparam int unsigned QuietCycles = 120;
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned ShownErrors = 40;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } out_word_t;

  class post_effect_tracker;
    mode_e                 cur_mode;
    logic [ParamOneW-1:0]  knob_one;
    logic [ParamTwoW-1:0]  knob_two;
    logic [SizeW-1:0]      row_len;
    logic [SizeW-1:0]      frame_rows;
    logic [ColW-1:0]       col;
    logic [RowW-1:0]       row;
    logic [PixW-1:0]       delay_px [MaxOffset];
    int unsigned           delay_cnt;
    out_word_t             upcoming [$];
    int unsigned           errors;

    function new();
      cur_mode   = MODE_NOISE;
      knob_one   = 1;
      knob_two   = 1;
      row_len    = 640;
      frame_rows = 480;
      col        = 0;
      row        = 0;
      delay_cnt  = 0;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_EFFECT_MODE:  cur_mode   = mode_e'(v[1:0]);
        CFG_PARAM_ONE:    knob_one   = v[ParamOneW-1:0];
        CFG_PARAM_TWO:    knob_two   = v[ParamTwoW-1:0];
        CFG_FRAME_WIDTH:  row_len    = v[SizeW-1:0];
        CFG_FRAME_HEIGHT: frame_rows = v[SizeW-1:0];
        default: ;
      endcase
    endfunction

    // a zero divisor counts as one
    function int unsigned div_one();
      return (knob_one == 0) ? 1 : knob_one;
    endfunction

    function int unsigned div_two();
      return (knob_two == 0) ? 1 : knob_two;
    endfunction

    function logic [PixW-1:0] noise_px(logic [PixW-1:0] p, logic [RandW-1:0] gate,
                                       logic [RandW-1:0] noise);
      logic [PixW-1:0] r;
      int unsigned     c;
      if (gate % div_one() != 0) return p;
      r = p;
      for (int k = 0; k < 3; k++) begin
        c = p[8*k +: 8] + noise[8*k +: 8] % div_two();
        r[8*k +: 8] = (c > 255) ? 8'hFF : c[7:0];
      end
      return r;
    endfunction

    function logic [PixW-1:0] ghost_mix(logic [PixW-1:0] p, logic [PixW-1:0] nb);
      logic [PixW-1:0] r;
      int unsigned     c;
      r = p;
      for (int k = 0; k < 3; k++) begin
        c = p[8*k +: 8] + nb[8*k +: 8] / div_two();
        r[8*k +: 8] = (c > 255) ? 8'hFF : c[7:0];
      end
      return r;
    endfunction

    function logic [PixW-1:0] scan_px(logic [PixW-1:0] p);
      logic [PixW-1:0] r;
      int unsigned     c;
      if (row % div_one() != 0) return p;
      r = p;
      for (int k = 0; k < 3; k++) begin
        c = p[8*k +: 8];
        r[8*k +: 8] = (c >= knob_two) ? 8'(c - knob_two) : 8'd0;
      end
      return r;
    endfunction

    function void shift_line();
      for (int i = 0; i + 1 < delay_cnt; i++) delay_px[i] = delay_px[i+1];
      if (delay_cnt > 0) delay_cnt--;
    endfunction

    function void note_pixel(logic [PixW-1:0] p, logic [RandW-1:0] gate,
                             logic [RandW-1:0] noise);
      out_word_t       burst [$];
      logic [PixW-1:0] r;
      int unsigned     width, height, offset;
      bit              row_end;
      width  = (row_len == 0) ? 1 : row_len;
      height = (frame_rows == 0) ? 1 : frame_rows;
      if (width > MaxWidth) width = MaxWidth;
      if (height > MaxHeight) height = MaxHeight;
      offset = 0;
      if (cur_mode == MODE_GHOST) offset = (knob_one > MaxOffset) ? MaxOffset : knob_one;
      row_end = (int'(col) + 1 >= width);

      // pixels beyond the current offset leave untouched, oldest first
      while (delay_cnt > offset) begin
        burst.push_back('{delay_px[0], 1'b0});
        shift_line();
      end

      if (cur_mode != MODE_GHOST) begin
        case (cur_mode)
          MODE_NOISE: r = noise_px(p, gate, noise);
          MODE_SCAN:  r = scan_px(p);
          default:    r = p;
        endcase
        burst.push_back('{r, 1'b0});
      end else if (offset == 0) begin
        burst.push_back('{ghost_mix(p, p), 1'b0});
      end else begin
        if (delay_cnt == offset) begin
          burst.push_back('{ghost_mix(delay_px[0], p), 1'b0});
          shift_line();
        end
        delay_px[delay_cnt] = p;
        delay_cnt++;
        // row end flushes the tail of the row unchanged
        if (row_end) begin
          for (int i = 0; i < delay_cnt; i++) burst.push_back('{delay_px[i], 1'b0});
          delay_cnt = 0;
        end
      end

      if (row_end) begin
        col = 0;
        row = (int'(row) + 1 >= height) ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end

      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) upcoming.push_back(burst[i]);
    endfunction

    function void check_pixel(logic [PixW-1:0] px, logic last);
      out_word_t want;
      if (upcoming.size() == 0) begin
        errors++;
        if (errors <= ShownErrors)
          $display("%0t: word %08h (last %0b) arrived with none expected", $time, px, last);
        return;
      end
      want = upcoming.pop_front();
      if (px !== want.pixel) begin
        errors++;
        if (errors <= ShownErrors)
          $display("%0t: pixel expected %08h, got %08h", $time, want.pixel, px);
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= ShownErrors)
          $display("%0t: last expected %0b, got %0b (pixel %08h)", $time, want.last, last, px);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [PixW-1:0]      m_axis_tdata;
  logic                 m_axis_tlast;

  post_effect_tracker   tracker = new();
  bit                   sender_calm;
  int unsigned          hold_off_req;
  mode_e                drive_mode;
  int unsigned          drive_one;
  int unsigned          cycle_count = 0;

  pixel_post_effect_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample every handshake at the edge, inputs before outputs
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.set_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_pixel(s_axis_tdata[31:0], s_axis_tdata[62:32], s_axis_tdata[93:63]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_pixel(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out with %0d words outstanding", $time, tracker.upcoming.size());
      $display("FAIL");
      $finish;
    end
  end

  // output side: random stalls, calm stretches and one long hold-off on request
  initial begin : receiver
    bit          calm;
    int unsigned r;
    int unsigned holds_done;
    calm = 1'b0;
    holds_done = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        if ($urandom_range(0, 199) == 0) calm = !calm;
        r = $urandom_range(0, 99);
        if (r < 2 && !calm) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk_i);
        end else begin
          m_axis_tready <= calm || (r >= 30);
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 100);
  endfunction

  // valid stays high after acceptance; the caller lowers it at the end of a phase
  task automatic send_pixel(logic [PixW-1:0] p, logic [RandW-1:0] gate,
                            logic [RandW-1:0] noise);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, noise, gate, p};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_pixel();
    logic [PixW-1:0]  p;
    logic [RandW-1:0] gate;
    logic [RandW-1:0] noise;
    int unsigned      d;
    p     = $urandom;
    gate  = RandW'($urandom);
    noise = RandW'($urandom);
    // bias the gate toward hits in noise mode, which matters when the chance divisor is large
    if (drive_mode == MODE_NOISE && $urandom_range(0, 2) == 0) begin
      d    = (drive_one == 0) ? 1 : drive_one;
      gate = gate - RandW'(gate % d);
    end
    send_pixel(p, gate, noise);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(mode_e m, int unsigned a, int unsigned b, int unsigned w,
                           int unsigned h);
    write_reg(CFG_EFFECT_MODE, m);
    write_reg(CFG_PARAM_ONE, a);
    write_reg(CFG_PARAM_TWO, b);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    drive_mode = m;
    drive_one  = a;
  endtask

  // all words out, then room for an item still in flight that makes no word
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    // let the sampler note the last accepted word first
    @(negedge clk_i);
    while (tracker.upcoming.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic pick_setting(int unsigned phase, output int unsigned items);
    mode_e       m;
    int unsigned a, b, w, h, r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      m = MODE_NOISE;
      case ($urandom_range(0, 3))
        0: a = $urandom_range(0, 3);
        1: a = $urandom_range(4, 16);
        2: a = $urandom_range(0, 65535);
        default: a = 65535;
      endcase
    end else if (r < 7) begin
      m = MODE_GHOST;
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 65535) : $urandom_range(0, 31);
    end else if (r < 9) begin
      m = MODE_SCAN;
      a = $urandom_range(0, 4);
    end else begin
      m = MODE_PASS;
      a = $urandom_range(0, 65535);
    end
    case ($urandom_range(0, 5))
      0: b = 0;
      1: b = 256;
      2: b = $urandom_range(257, 511);
      default: b = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 19))
      0: w = 0;
      1: w = 4096;
      2: w = 8191;
      default: w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0: h = 0;
      1: h = 4096;
      2: h = 8191;
      default: h = $urandom_range(1, 6);
    endcase
    items = $urandom_range(4, 30);
    // first phase: full offset and a row just wide enough for the longest run
    if (phase == 0) begin
      m     = MODE_GHOST;
      a     = 31;
      b     = $urandom_range(1, 4);
      w     = 32;
      h     = 2;
      items = 70;
    end
    configure(m, a, b, w, h);
  endtask

  initial begin : stimulus
    int unsigned sent, phase, items;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_EFFECT_MODE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sender_calm   = 1'b0;
    hold_off_req  = 0;
    drive_mode    = MODE_NOISE;
    drive_one     = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults after reset, field extremes
    send_pixel(32'h0000_0000, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_pixel(32'h80FE_0102, 31'h5555_5555, 31'h2AAA_AAAA);
    wait_drained();

    // zero chance divisor, noise range above a byte, zero frame size
    configure(MODE_NOISE, 0, 300, 0, 0);
    send_pixel(32'h00FF_FF80, 31'h0000_0005, 31'h7FFF_FFFF);
    send_pixel(32'hFF00_0000, 31'h0000_0000, 31'h7F80_FF01);
    send_pixel(32'h7F7F_7F7F, 31'h7FFF_FFFF, 31'h0010_2030);
    wait_drained();

    // gate miss then hit, oversize frame saturates
    configure(MODE_NOISE, 3, 256, 8191, 8191);
    send_pixel(32'h1020_3040, 31'h0000_0007, 31'h00FF_FFFF);
    send_pixel(32'h1020_3040, 31'h0000_0009, 31'h00FF_FFFF);
    wait_drained();

    // every row darkened, amount floors every channel; width shrinks mid-row
    configure(MODE_SCAN, 0, 256, 1, 1);
    send_pixel(32'hFFFF_FFFF, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'h12FF_0080, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    wait_drained();

    configure(MODE_SCAN, 2, 40, 1, 4096);
    send_pixel(32'hAA30_2850, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'hAA30_2850, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'hAA30_2850, 31'h0000_0000, 31'h0000_0000);
    wait_drained();

    // unused mode passes pixels through
    configure(MODE_PASS, 5, 7, 4, 4);
    send_pixel(32'hDEAD_BEEF, 31'h0000_0000, 31'h7FFF_FFFF);
    send_pixel(32'h0123_4567, 31'h7FFF_FFFF, 31'h0000_0000);
    wait_drained();

    // ghost with zero offset and zero depth divisor mixes each pixel with itself
    configure(MODE_GHOST, 0, 0, 4, 4);
    send_pixel(32'h3380_7F01, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'hFFFF_FFFF, 31'h0000_0000, 31'h0000_0000);
    wait_drained();

    // offset saturates and the row is narrower than it
    configure(MODE_GHOST, 65535, 1, 3, 4);
    send_pixel(32'h0102_0304, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'hF0F0_F0F0, 31'h0000_0000, 31'h0000_0000);
    send_pixel(32'h0F0F_0F0F, 31'h0000_0000, 31'h0000_0000);
    wait_drained();

    // mode changes while the delay line still holds pixels
    configure(MODE_GHOST, 4, 2, 10, 4);
    repeat (6) send_random_pixel();
    wait_drained();
    configure(MODE_NOISE, 2, 100, 10, 4);
    send_random_pixel();
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      pick_setting(phase, items);
      sender_calm = ($urandom_range(0, 3) == 0);
      // one long receiver hold-off with the sender pushing hard
      if (phase == 3) begin
        sender_calm  = 1'b1;
        items        = 30;
        hold_off_req++;
      end
      repeat (items) send_random_pixel();
      sent += items;
      phase++;
      wait_drained();
    end
    sender_calm = 1'b0;

    if (tracker.errors == 0 && tracker.upcoming.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
